// ===== src/timed_event_playback_macros.svh =====
// Assertion macros for the timed event playback block.
// Expects signals named clk and rst in the scope of each use.
`ifndef TIMED_EVENT_PLAYBACK_MACROS_SVH
`define TIMED_EVENT_PLAYBACK_MACROS_SVH

// Plain property check, held off while reset is high.
`define TEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication check, held off while reset is high.
`define TEP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/tep_pkg.sv =====
// Shared types and constants for the timed event playback block.
// No dependencies.
`timescale 1ns / 1ps
package tep_pkg;

  localparam int MAX_EVENTS_DEF = 1024;
  localparam int MAX_BURST_DEF  = 64;

  localparam int TIME_W    = 32;
  localparam int PAYLOAD_W = 24;
  localparam int ELAPSED_W = 24;
  localparam int INDEX_W   = 10;

  localparam logic KIND_MSG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PEND,
    EMIT_STATUS
  } emit_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  append;
    logic  rewind;
    logic  clear_list;
    logic  tick_start;
    logic  take;
    logic  sub_wait;
    logic  calc_wait;
    emit_t emit_sel;
    logic  emit_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic at_end;
    logic due;
    logic burst_full;
    logic next_eol;
    logic have_pend;
  } sts_t;

endpackage

// ===== src/tep_datapath.sv =====
// Datapath: message stores, playback counters, pending and output registers.
// Depends on tep_pkg and timed_event_playback_macros.svh.
`timescale 1ns / 1ps
`include "timed_event_playback_macros.svh"
module tep_datapath import tep_pkg::*; #(
  parameter int MAX_EVENTS = MAX_EVENTS_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [TIME_W-1:0]    event_time,
  input  logic [PAYLOAD_W-1:0] event_payload,
  input  logic [ELAPSED_W-1:0] elapsed_usecs,
  output logic                 strobe,
  output logic                 kind,
  output logic [TIME_W-1:0]    wait_usecs,
  output logic [PAYLOAD_W-1:0] payload,
  output logic [INDEX_W-1:0]   event_index,
  output logic                 end_of_list,
  output logic                 last
);

  localparam int ADDR_W  = $clog2(MAX_EVENTS);
  localparam int CNT_W   = $clog2(MAX_EVENTS + 1);
  localparam int BURST_W = $clog2(MAX_BURST + 1);

  logic [TIME_W-1:0]    time_mem [MAX_EVENTS];
  logic [PAYLOAD_W-1:0] pay_mem  [MAX_EVENTS];

  logic [TIME_W-1:0]    rd_time;
  logic [PAYLOAD_W-1:0] rd_pay;

  logic [CNT_W-1:0]   event_count;
  logic [CNT_W-1:0]   next_index;
  logic [CNT_W-1:0]   next_plus;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  elapsed_next;
  logic [TIME_W:0]    elapsed_sum;
  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  prev_time;
  logic [BURST_W-1:0] burst_cnt;

  logic                 pend_eol;
  logic [TIME_W-1:0]    pend_wait;
  logic [PAYLOAD_W-1:0] pend_pay;
  logic [INDEX_W-1:0]   pend_idx;

  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic             wr_en;

  assign next_plus    = next_index + CNT_W'(1);
  assign elapsed_sum  = {1'b0, elapsed} + (TIME_W + 1)'(elapsed_usecs);
  assign elapsed_next = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];

  assign wr_en   = cmd.append && (event_count < CNT_W'(MAX_EVENTS));
  assign rd_en   = cmd.tick_start || cmd.take;
  assign rd_addr = cmd.take ? next_plus[ADDR_W-1:0] : next_index[ADDR_W-1:0];

  always_comb begin
    sts.at_end     = (next_index >= event_count);
    sts.due        = (elapsed >= gap);
    sts.burst_full = (burst_cnt >= BURST_W'(MAX_BURST));
    sts.next_eol   = (next_plus >= event_count);
    sts.have_pend  = (burst_cnt != '0);
  end

  // Message stores: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[event_count[ADDR_W-1:0]] <= event_time;
      pay_mem[event_count[ADDR_W-1:0]]  <= event_payload;
    end
    if (rd_en) begin
      rd_time <= time_mem[rd_addr];
      rd_pay  <= pay_mem[rd_addr];
    end
  end

  // Playback counters
  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= '0;
      next_index  <= '0;
      elapsed     <= '0;
      gap         <= '0;
      burst_cnt   <= '0;
    end else begin
      if (wr_en) event_count <= event_count + CNT_W'(1);
      if (cmd.clear_list) event_count <= '0;
      if (cmd.rewind) begin
        next_index <= '0;
        elapsed    <= '0;
        gap        <= '0;
      end
      if (cmd.tick_start) begin
        elapsed   <= elapsed_next;
        burst_cnt <= '0;
      end
      if (cmd.take) begin
        next_index <= next_plus;
        burst_cnt  <= burst_cnt + BURST_W'(1);
      end
      if (cmd.sub_wait) elapsed <= elapsed - gap;
      if (cmd.calc_wait) gap <= rd_time - prev_time;
    end
  end

  // Pending message, held until it is known whether it closes the tick
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prev_time <= rd_time;
      pend_wait <= gap;
      pend_pay  <= rd_pay;
      pend_idx  <= INDEX_W'(next_index);
      pend_eol  <= sts.next_eol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= (cmd.emit_sel != EMIT_NONE);
  end

  always_ff @(posedge clk) begin
    case (cmd.emit_sel)
      EMIT_PEND: begin
        kind        <= KIND_MSG;
        wait_usecs  <= pend_wait;
        payload     <= pend_pay;
        event_index <= pend_idx;
        end_of_list <= pend_eol;
        last        <= cmd.emit_last;
      end
      EMIT_STATUS: begin
        kind        <= KIND_STATUS;
        wait_usecs  <= gap;
        payload     <= '0;
        event_index <= INDEX_W'(next_index);
        end_of_list <= sts.at_end;
        last        <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  `TEP_ASSERT(a_index_in_list, next_index <= event_count, "play index beyond list")
  `TEP_ASSERT(a_burst_bound, burst_cnt <= BURST_W'(MAX_BURST), "burst count overrun")
  `TEP_ASSERT_IMPL(a_status_last, strobe && (kind == KIND_STATUS), last, "status not last")

endmodule

// ===== src/tep_ctrl.sv =====
// Controller: sequences appends, rewinds and tick playback over the datapath.
// Depends on tep_pkg and timed_event_playback_macros.svh.
`timescale 1ns / 1ps
`include "timed_event_playback_macros.svh"
module tep_ctrl import tep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && (op == OP_TICK) && !sts.at_end) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.due && !sts.burst_full) begin
          state_next = sts.next_eol ? ST_FLUSH : ST_CALC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CALC:  state_next = ST_CHECK;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.emit_sel = EMIT_NONE;
    busy     = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_APPEND:  cmd.append = 1'b1;
            OP_RESTART: cmd.rewind = 1'b1;
            OP_CLEAR: begin
              cmd.rewind     = 1'b1;
              cmd.clear_list = 1'b1;
            end
            OP_TICK: begin
              if (sts.at_end) cmd.emit_sel = EMIT_STATUS;
              else            cmd.tick_start = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.due && !sts.burst_full) begin
          cmd.take = 1'b1;
          cmd.sub_wait = !sts.next_eol;
          if (sts.have_pend) cmd.emit_sel = EMIT_PEND;
        end else begin
          cmd.emit_sel  = sts.have_pend ? EMIT_PEND : EMIT_STATUS;
          cmd.emit_last = 1'b1;
        end
      end
      ST_CALC: cmd.calc_wait = 1'b1;
      ST_FLUSH: begin
        cmd.emit_sel  = EMIT_PEND;
        cmd.emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  `TEP_ASSERT_IMPL(a_check_not_end, state == ST_CHECK, !sts.at_end, "check with list spent")
  `TEP_ASSERT_IMPL(a_flush_at_end, state == ST_FLUSH, sts.at_end, "flush before list end")

endmodule

// ===== src/timed_event_playback.sv =====
// Top level of the timed event playback block.
// Depends on tep_pkg, tep_ctrl and tep_datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive op and its fields with start high; the item is taken
//   at a rising edge where start is high and busy is low. Append stores one
//   timestamped message, restart rewinds playback, clear also empties the
//   list; each of these gives no result.
//   A tick adds elapsed_usecs to elapsed time (saturating) and plays every due
//   message, at most MAX_BURST of them. Each message takes a memory read of
//   the next timestamp and payload, then a step that forms the new wait.
//   Output channel: each item shows for one cycle with strobe high; the last
//   item of a tick carries last. A tick with nothing due, or with the list
//   spent, gives a single status item. Results show in the cycle after the
//   decision that makes them, so the final item of a tick shows in the first
//   cycle with busy low.
//   The receiver cannot stall; there is no back-pressure on results.
//   Reset (synchronous, active high) empties the list and zeroes playback
//   state; message store contents are left as they are and are not cleared.
module timed_event_playback import tep_pkg::*; #(
  parameter int MAX_EVENTS = MAX_EVENTS_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [TIME_W-1:0]    event_time,
  input  logic [PAYLOAD_W-1:0] event_payload,
  input  logic [ELAPSED_W-1:0] elapsed_usecs,
  output logic                 strobe,
  output logic                 kind,
  output logic [TIME_W-1:0]    wait_usecs,
  output logic [PAYLOAD_W-1:0] payload,
  output logic [INDEX_W-1:0]   event_index,
  output logic                 end_of_list,
  output logic                 last
);

  cmd_t cmd;
  sts_t sts;

  // Sequence item handling and the per-message playback loop
  tep_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the message list, playback counters and result registers
  tep_datapath #(
    .MAX_EVENTS (MAX_EVENTS),
    .MAX_BURST  (MAX_BURST)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .event_time    (event_time),
    .event_payload (event_payload),
    .elapsed_usecs (elapsed_usecs),
    .strobe        (strobe),
    .kind          (kind),
    .wait_usecs    (wait_usecs),
    .payload       (payload),
    .event_index   (event_index),
    .end_of_list   (end_of_list),
    .last          (last)
  );

endmodule
